FILE: rtl/color_keyed_sprite_column_blit_defines.svh
// Assertion macros of the sprite column blitter checker.
`ifndef COLOR_KEYED_SPRITE_COLUMN_BLIT_DEFINES_SVH
`define COLOR_KEYED_SPRITE_COLUMN_BLIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled in reset.
`define CKSCB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled in reset.
`define CKSCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ckscb_pkg.sv
// Types and constants of the sprite column blitter.
package ckscb_pkg;

    // Request kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ROW_PITCH     = 2'd2;
    localparam logic [1:0] REG_PIXEL_BYTES   = 2'd3;

    // Reset values of the configuration registers
    localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd320;
    localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd200;
    localparam logic [12:0] RST_ROW_PITCH     = 13'd320;
    localparam logic [2:0]  RST_PIXEL_BYTES   = 3'd1;

    // Pixel size codes that draw
    localparam logic [2:0] PB_ONE  = 3'd1;
    localparam logic [2:0] PB_TWO  = 3'd2;
    localparam logic [2:0] PB_FOUR = 3'd4;

    // Tallest column in rows
    localparam logic [6:0] MAX_ROWS = 7'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic [12:0] row_pitch;
        logic [31:0] pixel_mask;
        logic        draw_ok;
    } cfg_t;

    typedef struct packed {
        logic [11:0] column;
        logic [12:0] x_origin;
        logic [12:0] y_origin;
        logic [12:0] sprite_width;
        logic [6:0]  sprite_height;
        logic [2:0]  column_shift;
        logic        outline;
    } draw_t;

    typedef struct packed {
        logic        active;
        logic [6:0]  rows;
        logic [23:0] addr0;
    } plan_t;

endpackage

FILE: rtl/ckscb_if.sv
// Request and pixel-write channel interfaces of the sprite column blitter.
interface ckscb_req_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [11:0]        texel_index;
    logic [31:0]        texel_value;
    logic [11:0]        column;
    logic signed [12:0] x_origin;
    logic signed [12:0] y_origin;
    logic [12:0]        sprite_width;
    logic [6:0]         sprite_height;
    logic [2:0]         column_shift;
    logic               outline;

    modport source (
        output valid, kind, texel_index, texel_value, column, x_origin, y_origin,
               sprite_width, sprite_height, column_shift, outline,
        input  ready
    );
    modport sink (
        input  valid, kind, texel_index, texel_value, column, x_origin, y_origin,
               sprite_width, sprite_height, column_shift, outline,
        output ready
    );
endinterface

interface ckscb_pix_if;
    logic        valid;
    logic        ready;
    logic [23:0] fb_address;
    logic [31:0] pixel_value;
    logic        last;

    modport source (
        output valid, fb_address, pixel_value, last,
        input  ready
    );
    modport sink (
        input  valid, fb_address, pixel_value, last,
        output ready
    );
endinterface

FILE: rtl/color_keyed_sprite_column_blit.sv
// Top level of the color-keyed sprite column blitter.
//
// Requests arrive on draw_in. A load request writes one texel into the texture
// store and is done in its accept cycle; ready stays high after it. A draw
// request names one sprite column; after its accept cycle the block passes a
// setup state for clipping and the start address, then reads one texel a cycle
// from the store for each visible row unless the walk stalls. The texture
// store's single read port sets that rate. Opaque texels go through a hold
// register and the output register to pix_out as framebuffer writes; one write
// is held back so the final one can carry last. draw_in.ready is low for the
// whole draw. When pix_out stalls and an opaque texel cannot enter the hold
// register, the row walk stops and the store read data holds; nothing is
// dropped. Configuration goes through cfg_we, cfg_index and cfg_data while the
// block is idle, as the user must ensure; the block does not enforce it. Reset
// returns the registers to their reset values and empties the pipeline; the
// texture store is not cleared and is undefined until loaded.
module color_keyed_sprite_column_blit #(
    parameter int STORE_WORDS      = 4096,
    parameter int MAX_COLUMN_SHIFT = 6
) (
    input  logic         clk,
    input  logic         rst_n,
    ckscb_req_if.sink    draw_in,
    ckscb_pix_if.source  pix_out,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [12:0]  cfg_data
);

    localparam int AW = $clog2(STORE_WORDS);

    ckscb_pkg::cfg_t   cfg;
    ckscb_pkg::plan_t  plan;
    ckscb_pkg::draw_t  draw_reg;
    ckscb_pkg::state_t state_reg;
    ckscb_pkg::state_t state_next;

    logic [AW-1:0] start_idx;
    logic [AW-1:0] rd_idx_reg;
    logic [6:0]    rows_left_reg;
    logic [23:0]   addr_cnt_reg;
    logic          rv_reg;
    logic [23:0]   d_addr_reg;
    logic          hold_v_reg;
    logic [23:0]   hold_addr_reg;
    logic [31:0]   hold_val_reg;
    logic          out_v_reg;
    logic [23:0]   out_addr_reg;
    logic [31:0]   out_val_reg;
    logic          out_last_reg;

    logic [31:0]   rdata;
    logic [31:0]   texel;
    logic          accept;
    logic          load_we;
    logic          transparent;
    logic          out_free;
    logic          hold_ok;
    logic          d_consume;
    logic          issue;
    logic          push_opaque;
    logic          flush_move;
    logic          hold_to_out;

    ckscb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ckscb_clip #(
        .AW               (AW),
        .MAX_COLUMN_SHIFT (MAX_COLUMN_SHIFT)
    ) u_clip (
        .draw      (draw_reg),
        .cfg       (cfg),
        .plan      (plan),
        .start_idx (start_idx)
    );

    ckscb_ram #(
        .WIDTH (32),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (load_we),
        .waddr (AW'(draw_in.texel_index)),
        .wdata (draw_in.texel_value),
        .re    (issue),
        .raddr (rd_idx_reg),
        .rdata (rdata)
    );

    // Accept requests only when idle; loads never overlap a draw's reads
    assign draw_in.ready = (state_reg == ckscb_pkg::ST_IDLE);
    assign accept        = draw_in.valid && draw_in.ready;
    assign load_we       = accept && (draw_in.kind == ckscb_pkg::KIND_LOAD);

    // Color key test on the read data
    assign texel       = rdata & cfg.pixel_mask;
    assign transparent = (texel == cfg.pixel_mask);

    // Backpressure chain: output, hold, read data, next read
    assign out_free    = !out_v_reg || pix_out.ready;
    assign hold_ok     = !hold_v_reg || out_free;
    assign d_consume   = rv_reg && (transparent || hold_ok);
    assign issue       = (state_reg == ckscb_pkg::ST_RUN) && (rows_left_reg != 7'd0) &&
                         (!rv_reg || d_consume);
    assign push_opaque = rv_reg && !transparent && hold_ok;
    assign flush_move  = (state_reg == ckscb_pkg::ST_FLUSH) && hold_v_reg && out_free;
    assign hold_to_out = (push_opaque && hold_v_reg) || flush_move;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ckscb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ckscb_pkg::ST_IDLE:
            begin
                if (accept && (draw_in.kind == ckscb_pkg::KIND_DRAW))
                begin
                    state_next = ckscb_pkg::ST_SETUP;
                end
            end
            ckscb_pkg::ST_SETUP:
            begin
                state_next = plan.active ? ckscb_pkg::ST_RUN : ckscb_pkg::ST_IDLE;
            end
            ckscb_pkg::ST_RUN:
            begin
                if ((rows_left_reg == 7'd0) && !rv_reg)
                begin
                    state_next = ckscb_pkg::ST_FLUSH;
                end
            end
            ckscb_pkg::ST_FLUSH:
            begin
                if (!hold_v_reg || out_free)
                begin
                    state_next = ckscb_pkg::ST_IDLE;
                end
            end
            default: state_next = ckscb_pkg::ST_IDLE;
        endcase
    end

    // Capture draw fields, clamping the height
    always_ff @(posedge clk)
    begin
        if (accept && (draw_in.kind == ckscb_pkg::KIND_DRAW))
        begin
            draw_reg.column        <= draw_in.column;
            draw_reg.x_origin      <= draw_in.x_origin;
            draw_reg.y_origin      <= draw_in.y_origin;
            draw_reg.sprite_width  <= draw_in.sprite_width;
            draw_reg.sprite_height <= (draw_in.sprite_height > ckscb_pkg::MAX_ROWS) ?
                                      ckscb_pkg::MAX_ROWS : draw_in.sprite_height;
            draw_reg.column_shift  <= draw_in.column_shift;
            draw_reg.outline       <= draw_in.outline;
        end
    end

    // Row walk counters: load at setup, advance on each read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_left_reg <= 7'd0;
        end
        else if (state_reg == ckscb_pkg::ST_SETUP)
        begin
            rows_left_reg <= plan.active ? plan.rows : 7'd0;
        end
        else if (issue)
        begin
            rows_left_reg <= rows_left_reg - 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ckscb_pkg::ST_SETUP)
        begin
            rd_idx_reg   <= start_idx;
            addr_cnt_reg <= plan.addr0;
        end
        else if (issue)
        begin
            rd_idx_reg   <= rd_idx_reg - AW'(1);
            addr_cnt_reg <= addr_cnt_reg + {11'd0, cfg.row_pitch};
        end
    end

    // Read data stage: valid flag and its framebuffer address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
        end
        else if (issue)
        begin
            rv_reg <= 1'b1;
        end
        else if (d_consume)
        begin
            rv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            d_addr_reg <= addr_cnt_reg;
        end
    end

    // Hold the newest opaque write until the next one or the flush
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
        end
        else if (push_opaque)
        begin
            hold_v_reg <= 1'b1;
        end
        else if (flush_move)
        begin
            hold_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_opaque)
        begin
            hold_addr_reg <= d_addr_reg;
            hold_val_reg  <= draw_reg.outline ? 32'd0 : texel;
        end
    end

    // Output register: load from hold, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (hold_to_out)
        begin
            out_v_reg <= 1'b1;
        end
        else if (pix_out.ready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_to_out)
        begin
            out_addr_reg <= hold_addr_reg;
            out_val_reg  <= hold_val_reg;
            out_last_reg <= flush_move;
        end
    end

    assign pix_out.valid       = out_v_reg;
    assign pix_out.fb_address  = out_addr_reg;
    assign pix_out.pixel_value = out_val_reg;
    assign pix_out.last        = out_last_reg;

endmodule

FILE: rtl/ckscb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ckscb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/ckscb_cfg.sv
// Configuration registers and pixel mask decode of the sprite column blitter.
module ckscb_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [12:0]         cfg_data,
    output ckscb_pkg::cfg_t     cfg
);

    logic [12:0] screen_width_reg;
    logic [12:0] screen_height_reg;
    logic [12:0] row_pitch_reg;
    logic [2:0]  pixel_bytes_reg;

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= ckscb_pkg::RST_SCREEN_WIDTH;
            screen_height_reg <= ckscb_pkg::RST_SCREEN_HEIGHT;
            row_pitch_reg     <= ckscb_pkg::RST_ROW_PITCH;
            pixel_bytes_reg   <= ckscb_pkg::RST_PIXEL_BYTES;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ckscb_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                ckscb_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                ckscb_pkg::REG_ROW_PITCH:     row_pitch_reg     <= cfg_data;
                ckscb_pkg::REG_PIXEL_BYTES:   pixel_bytes_reg   <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Decode pixel size into a byte mask
    always_comb
    begin
        cfg.screen_width  = screen_width_reg;
        cfg.screen_height = screen_height_reg;
        cfg.row_pitch     = row_pitch_reg;
        unique case (pixel_bytes_reg)
            ckscb_pkg::PB_ONE:
            begin
                cfg.pixel_mask = 32'h0000_00FF;
                cfg.draw_ok    = 1'b1;
            end
            ckscb_pkg::PB_TWO:
            begin
                cfg.pixel_mask = 32'h0000_FFFF;
                cfg.draw_ok    = 1'b1;
            end
            ckscb_pkg::PB_FOUR:
            begin
                cfg.pixel_mask = 32'hFFFF_FFFF;
                cfg.draw_ok    = 1'b1;
            end
            default:
            begin
                cfg.pixel_mask = 32'hFFFF_FFFF;
                cfg.draw_ok    = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/ckscb_clip.sv
// Column clipping, first texel index and first framebuffer address of a draw.
module ckscb_clip #(
    parameter int AW               = 12,
    parameter int MAX_COLUMN_SHIFT = 6
) (
    input  ckscb_pkg::draw_t draw,
    input  ckscb_pkg::cfg_t  cfg,
    output ckscb_pkg::plan_t plan,
    output logic [AW-1:0]    start_idx
);

    // Shift can never exceed what the 3-bit field carries
    localparam int SHW = (MAX_COLUMN_SHIFT < 7) ? MAX_COLUMN_SHIFT : 7;
    localparam int BW  = 13 + SHW;
    localparam int IW  = ((BW > AW) ? BW : AW) + 1;

    logic signed [14:0] xo_s;
    logic signed [14:0] yo_s;
    logic signed [14:0] xs;
    logic signed [14:0] sw_s;
    logic signed [14:0] h_s;
    logic signed [14:0] shy;
    logic signed [14:0] dy;
    logic signed [14:0] iy;
    logic signed [14:0] rows_s;
    logic signed [14:0] start_off;
    logic               vis_x;
    logic [2:0]         shift_c;
    logic [12:0]        col_dist;
    logic [BW-1:0]      base;
    logic [IW-1:0]      idx_sum;
    logic [12:0]        row0;
    logic [25:0]        prod;

    // Horizontal visibility of the column
    assign xo_s  = {{2{draw.x_origin[12]}}, draw.x_origin};
    assign yo_s  = {{2{draw.y_origin[12]}}, draw.y_origin};
    assign xs    = $signed({3'b000, draw.column}) + xo_s;
    assign sw_s  = $signed({2'b00, cfg.screen_width});
    assign vis_x = !xs[14] && (xs < sw_s) && ({1'b0, draw.column} < draw.sprite_width);

    // Vertical row range after top and bottom clipping
    assign h_s       = $signed({8'd0, draw.sprite_height});
    assign shy       = $signed({2'b00, cfg.screen_height}) - yo_s;
    assign dy        = (h_s < shy) ? h_s : shy;
    assign iy        = yo_s[14] ? -yo_s : 15'sd0;
    assign rows_s    = dy - iy;
    assign start_off = h_s - 15'sd1 - iy;

    // Texel index of the first visible row, bottom-up column-major
    assign shift_c  = (32'(draw.column_shift) > MAX_COLUMN_SHIFT) ?
                      3'(MAX_COLUMN_SHIFT) : draw.column_shift;
    assign col_dist = draw.sprite_width - {1'b0, draw.column} - 13'd1;
    assign base     = BW'(col_dist) << shift_c;
    assign idx_sum  = IW'(base) + IW'(start_off[5:0]);
    assign start_idx = idx_sum[AW-1:0];

    // Framebuffer address of the first visible row
    assign row0 = yo_s[14] ? 13'd0 : draw.y_origin;
    assign prod = 26'(row0) * 26'(cfg.row_pitch);

    always_comb
    begin
        plan.active = vis_x && cfg.draw_ok && !rows_s[14] && (rows_s != 15'sd0);
        plan.rows   = rows_s[6:0];
        plan.addr0  = prod[23:0] + {11'd0, xs[12:0]};
    end

endmodule

FILE: rtl/ckscb_checker.sv
// Port-level checker of the sprite column blitter and its bind.
`include "color_keyed_sprite_column_blit_defines.svh"

module ckscb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_kind,
    input logic        out_valid,
    input logic        out_ready,
    input logic [23:0] out_address,
    input logic [31:0] out_value,
    input logic        out_last
);

    // A stalled write stays offered
    `CKSCB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "write dropped while stalled")

    // A stalled write keeps its payload
    `CKSCB_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_address) && $stable(out_value) && $stable(out_last), "stalled write changed")

    // A draw request closes the request channel for the next cycle
    `CKSCB_ASSERT_NEXT(a_draw_busy, in_valid && in_ready && (in_kind == ckscb_pkg::KIND_DRAW), !in_ready, "request taken during a draw")

    // A load request leaves the block ready
    `CKSCB_ASSERT_NEXT(a_load_ready, in_valid && in_ready && (in_kind == ckscb_pkg::KIND_LOAD), in_ready, "load stalled the request channel")

    // New writes come only out of a draw
    `CKSCB_ASSERT_SAME(a_write_in_draw, $rose(out_valid), $past(!in_ready), "write appeared outside a draw")

endmodule

bind color_keyed_sprite_column_blit ckscb_checker u_ckscb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (draw_in.valid),
    .in_ready    (draw_in.ready),
    .in_kind     (draw_in.kind),
    .out_valid   (pix_out.valid),
    .out_ready   (pix_out.ready),
    .out_address (pix_out.fb_address),
    .out_value   (pix_out.pixel_value),
    .out_last    (pix_out.last)
);

FILE: dv/tb.sv
// Self-checking testbench of the color-keyed sprite column blitter.
module tb;

    localparam int STORE_DEPTH    = 4096;
    localparam int SHIFT_LIMIT    = 6;
    localparam int QUIET_CYCLES   = 100;
    localparam int DRAIN_LIMIT    = 50000;
    localparam int PHASE_REQUESTS = 25;
    localparam int PHASE_COUNT    = 6;

    typedef struct packed {
        logic        kind;
        logic [11:0] texel_index;
        logic [31:0] texel_value;
        logic [11:0] column;
        logic [12:0] x_origin;
        logic [12:0] y_origin;
        logic [12:0] sprite_width;
        logic [6:0]  sprite_height;
        logic [2:0]  column_shift;
        logic        outline;
    } blit_req_t;

    typedef struct packed {
        logic [23:0] fb_address;
        logic [31:0] pixel_value;
        logic        last;
    } pix_write_t;

    // One directed request, optionally preceded by a pixel size change
    typedef struct {
        blit_req_t   req;
        bit          reconfig;
        logic [12:0] pb_data;
        bit          typed;
        int          typed_n;
        pix_write_t  typed_wr;
    } stim_row_t;

    localparam pix_write_t NO_WRITE = '0;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    ckscb_req_if req_ch ();
    ckscb_pix_if pix_ch ();

    color_keyed_sprite_column_blit #(
        .STORE_WORDS      (STORE_DEPTH),
        .MAX_COLUMN_SHIFT (SHIFT_LIMIT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .draw_in   (req_ch),
        .pix_out   (pix_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the block's store and registers
    logic [31:0] texel_mem [STORE_DEPTH];
    bit          texel_loaded [STORE_DEPTH];
    logic [12:0] scr_width;
    logic [12:0] scr_height;
    logic [12:0] fb_pitch;
    logic [2:0]  pix_bytes;

    pix_write_t  expected_writes [$];
    pix_write_t  oldest_write;
    stim_row_t   directed_rows [$];
    int          error_count = 0;
    bit          idle_off = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 95)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Bias texels toward the transparent key at each pixel size
    function automatic logic [31:0] random_texel();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: v = 32'hffff_ffff;
            1: v[7:0] = 8'hff;
            2: v[15:0] = 16'hffff;
            3: v = 32'h0;
            default: ;
        endcase
        return v;
    endfunction

    function automatic blit_req_t random_fields();
        blit_req_t r;
        r.kind          = 1'($urandom);
        r.texel_index   = 12'($urandom);
        r.texel_value   = $urandom;
        r.column        = 12'($urandom);
        r.x_origin      = 13'($urandom);
        r.y_origin      = 13'($urandom);
        r.sprite_width  = 13'($urandom);
        r.sprite_height = 7'($urandom);
        r.column_shift  = 3'($urandom);
        r.outline       = 1'($urandom);
        return r;
    endfunction

    function automatic blit_req_t make_load(input logic [11:0] idx, input logic [31:0] val);
        blit_req_t r;
        r = random_fields();
        r.kind        = ckscb_pkg::KIND_LOAD;
        r.texel_index = idx;
        r.texel_value = val;
        return r;
    endfunction

    function automatic blit_req_t make_draw(input int col, input int x, input int y,
                                            input int w, input int h, input int s,
                                            input bit ol);
        blit_req_t r;
        r = random_fields();
        r.kind          = ckscb_pkg::KIND_DRAW;
        r.column        = 12'(col);
        r.x_origin      = 13'(x);
        r.y_origin      = 13'(y);
        r.sprite_width  = 13'(w);
        r.sprite_height = 7'(h);
        r.column_shift  = 3'(s);
        r.outline       = ol;
        return r;
    endfunction

    function automatic int clamped_height(input blit_req_t r);
        return (r.sprite_height > ckscb_pkg::MAX_ROWS) ?
               int'(ckscb_pkg::MAX_ROWS) : int'(r.sprite_height);
    endfunction

    // Clip the column; return whether it shows and its visible row span
    function automatic bit visible_rows(input blit_req_t r, output int first_row,
                                        output int end_row);
        longint col, xo, yo, w, h, dx, dy, ix;
        col = longint'(r.column);
        xo  = longint'($signed(r.x_origin));
        yo  = longint'($signed(r.y_origin));
        w   = longint'(r.sprite_width);
        h   = clamped_height(r);
        dx  = w;
        if (longint'(scr_width) - xo < dx)
            dx = longint'(scr_width) - xo;
        dy = h;
        if (longint'(scr_height) - yo < dy)
            dy = longint'(scr_height) - yo;
        ix = (xo < 0) ? -xo : 0;
        first_row = (yo < 0) ? int'(-yo) : 0;
        end_row   = int'(dy);
        return (col >= ix) && (col < dx);
    endfunction

    // Column-major, rightmost column first, each column bottom-up
    function automatic logic [11:0] texel_addr(input blit_req_t r, input int row);
        longint base, h;
        int shift;
        h     = clamped_height(r);
        shift = (r.column_shift > SHIFT_LIMIT) ? SHIFT_LIMIT : int'(r.column_shift);
        base  = (longint'(r.sprite_width) - 1 - longint'(r.column)) << shift;
        return 12'((base + h - 1 - row) % STORE_DEPTH);
    endfunction

    // Work out the framebuffer writes of one draw request
    function automatic void predict_column(input blit_req_t r);
        pix_write_t  col_writes [$];
        logic [31:0] mask;
        logic [31:0] tex;
        logic [63:0] addr;
        int          first_row;
        int          end_row;
        case (pix_bytes)
            ckscb_pkg::PB_ONE:  mask = 32'h0000_00ff;
            ckscb_pkg::PB_TWO:  mask = 32'h0000_ffff;
            ckscb_pkg::PB_FOUR: mask = 32'hffff_ffff;
            default: return;
        endcase
        if (!visible_rows(r, first_row, end_row))
            return;
        for (int y = first_row; y < end_row; y++)
        begin
            tex = texel_mem[texel_addr(r, y)] & mask;
            // Skip the color key
            if (tex == mask)
                continue;
            addr = 64'(longint'(r.column) + longint'($signed(r.x_origin))
                       + (longint'($signed(r.y_origin)) + y) * longint'(fb_pitch));
            col_writes.push_back(pix_write_t'{addr[23:0], r.outline ? 32'h0 : tex, 1'b0});
        end
        if (col_writes.size() > 0)
            col_writes[col_writes.size() - 1].last = 1'b1;
        foreach (col_writes[i])
            expected_writes.push_back(col_writes[i]);
    endfunction

    function automatic void add_row(input blit_req_t r, input bit reconfig,
                                    input logic [12:0] pb, input bit typed,
                                    input int n, input pix_write_t wr);
        directed_rows.push_back('{r, reconfig, pb, typed, n, wr});
    endfunction

    // Present one request, hold it until accepted, then record what it causes
    task automatic send_request(input blit_req_t r, input bit typed, input int typed_n,
                                input pix_write_t typed_wr);
        int gap;
        gap = idle_off ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.kind          <= r.kind;
        req_ch.texel_index   <= r.texel_index;
        req_ch.texel_value   <= r.texel_value;
        req_ch.column        <= r.column;
        req_ch.x_origin      <= r.x_origin;
        req_ch.y_origin      <= r.y_origin;
        req_ch.sprite_width  <= r.sprite_width;
        req_ch.sprite_height <= r.sprite_height;
        req_ch.column_shift  <= r.column_shift;
        req_ch.outline       <= r.outline;
        do @(posedge clk); while (!req_ch.ready);
        if (r.kind == ckscb_pkg::KIND_LOAD)
        begin
            texel_mem[r.texel_index]    = r.texel_value;
            texel_loaded[r.texel_index] = 1'b1;
        end
        else if (typed)
        begin
            if (typed_n > 0)
                expected_writes.push_back(typed_wr);
        end
        else
        begin
            predict_column(r);
        end
    endtask

    // Load every texel a draw will read that has never been written
    task automatic issue(input blit_req_t r, input bit typed, input int typed_n,
                         input pix_write_t typed_wr);
        int          first_row;
        int          end_row;
        logic [11:0] idx;
        if (r.kind == ckscb_pkg::KIND_DRAW && visible_rows(r, first_row, end_row))
        begin
            for (int y = first_row; y < end_row; y++)
            begin
                idx = texel_addr(r, y);
                if (!texel_loaded[idx])
                    send_request(make_load(idx, random_texel()), 1'b0, 0, NO_WRITE);
            end
        end
        send_request(r, typed, typed_n, typed_wr);
    endtask

    // Drop valid, drain the pending writes, then let the block go quiet
    task automatic settle();
        int waited;
        waited = 0;
        req_ch.valid <= 1'b0;
        while (expected_writes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            ckscb_pkg::REG_SCREEN_WIDTH:  scr_width  = data;
            ckscb_pkg::REG_SCREEN_HEIGHT: scr_height = data;
            ckscb_pkg::REG_ROW_PITCH:     fb_pitch   = data;
            ckscb_pkg::REG_PIXEL_BYTES:   pix_bytes  = data[2:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Register settings of each random phase, extremes first
    task automatic configure_phase(input int phase);
        logic [2:0] pb;
        case (phase)
            0:
            begin
                write_reg(ckscb_pkg::REG_SCREEN_WIDTH, 13'd4096);
                write_reg(ckscb_pkg::REG_SCREEN_HEIGHT, 13'd4096);
                write_reg(ckscb_pkg::REG_ROW_PITCH, 13'd4096);
                write_reg(ckscb_pkg::REG_PIXEL_BYTES, {10'd0, ckscb_pkg::PB_FOUR});
            end
            1:
            begin
                write_reg(ckscb_pkg::REG_SCREEN_WIDTH, 13'd1);
                write_reg(ckscb_pkg::REG_SCREEN_HEIGHT, 13'd1);
                write_reg(ckscb_pkg::REG_ROW_PITCH, 13'd1);
                write_reg(ckscb_pkg::REG_PIXEL_BYTES, {10'h3ff, ckscb_pkg::PB_TWO});
            end
            2:
            begin
                write_reg(ckscb_pkg::REG_SCREEN_WIDTH, 13'h1fff);
                write_reg(ckscb_pkg::REG_SCREEN_HEIGHT, 13'h1fff);
                write_reg(ckscb_pkg::REG_ROW_PITCH, 13'h1fff);
                write_reg(ckscb_pkg::REG_PIXEL_BYTES, {10'd0, ckscb_pkg::PB_FOUR});
            end
            3:
            begin
                case ($urandom_range(0, 4))
                    0: pb = 3'd0;
                    1: pb = 3'd3;
                    2: pb = 3'd5;
                    3: pb = 3'd6;
                    default: pb = 3'd7;
                endcase
                write_reg(ckscb_pkg::REG_SCREEN_WIDTH, 13'($urandom_range(1, 640)));
                write_reg(ckscb_pkg::REG_SCREEN_HEIGHT, 13'($urandom_range(1, 480)));
                write_reg(ckscb_pkg::REG_ROW_PITCH, 13'($urandom_range(1, 8191)));
                write_reg(ckscb_pkg::REG_PIXEL_BYTES, {10'($urandom), pb});
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0: pb = ckscb_pkg::PB_ONE;
                    1: pb = ckscb_pkg::PB_TWO;
                    default: pb = ckscb_pkg::PB_FOUR;
                endcase
                write_reg(ckscb_pkg::REG_SCREEN_WIDTH, 13'($urandom_range(1, 4096)));
                write_reg(ckscb_pkg::REG_SCREEN_HEIGHT, 13'($urandom_range(1, 4096)));
                write_reg(ckscb_pkg::REG_ROW_PITCH, 13'($urandom_range(1, 8191)));
                write_reg(ckscb_pkg::REG_PIXEL_BYTES, {10'($urandom), pb});
            end
        endcase
        cfg_we <= 1'b0;
    endtask

    function automatic blit_req_t random_load();
        blit_req_t r;
        if ($urandom_range(0, 9) < 7)
            r = make_load(12'($urandom_range(0, 255)), random_texel());
        else
            r = make_load(12'($urandom), random_texel());
        return r;
    endfunction

    // Mostly columns that land on screen; the rest are raw field noise
    function automatic blit_req_t random_draw();
        blit_req_t r;
        int        hh;
        int        span;
        int        xv;
        int        yv;
        int        pick;
        r = random_fields();
        r.kind = ckscb_pkg::KIND_DRAW;
        if ($urandom_range(0, 9) < 8)
        begin
            if ($urandom_range(0, 9) == 0)
                r.sprite_width = 13'($urandom_range(1, 4096));
            else
                r.sprite_width = 13'($urandom_range(1, 12));
            if ($urandom_range(0, 9) == 0)
                r.column = 12'($urandom);
            else
                r.column = 12'($urandom_range(0, r.sprite_width - 1));
            pick = $urandom_range(0, 9);
            if (pick < 6)
                r.sprite_height = 7'($urandom_range(1, 16));
            else if (pick < 9)
                r.sprite_height = 7'($urandom_range(17, 64));
            else
                r.sprite_height = 7'($urandom_range(0, 127));
            r.column_shift = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
            span = (scr_width > 4096) ? 4096 : int'(scr_width);
            xv = int'($urandom_range(0, span - 1)) - int'(r.column);
            r.x_origin = 13'(xv);
            hh = clamped_height(r);
            span = (scr_height > 4096) ? 4096 : int'(scr_height);
            yv = int'($urandom_range(0, span - 1 + hh)) - hh;
            if (yv > 4095)
                yv = 4095;
            r.y_origin = 13'(yv);
        end
        return r;
    endfunction

    // Write side: random stalls with occasional long open stretches
    initial
    begin
        int stall;
        pix_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            pix_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            if ($urandom_range(0, 7) == 0)
                repeat (80) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                pix_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Compare each accepted write with the oldest pending one
    always @(posedge clk)
    begin
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            if (expected_writes.size() == 0)
            begin
                $error("unexpected write: fb_address %0h pixel_value %0h last %0b",
                       pix_ch.fb_address, pix_ch.pixel_value, pix_ch.last);
                error_count++;
            end
            else
            begin
                oldest_write = expected_writes.pop_front();
                if (pix_ch.fb_address !== oldest_write.fb_address)
                begin
                    $error("fb_address: expected %0h, actual %0h",
                           oldest_write.fb_address, pix_ch.fb_address);
                    error_count++;
                end
                if (pix_ch.pixel_value !== oldest_write.pixel_value)
                begin
                    $error("pixel_value: expected %0h, actual %0h",
                           oldest_write.pixel_value, pix_ch.pixel_value);
                    error_count++;
                end
                if (pix_ch.last !== oldest_write.last)
                begin
                    $error("last: expected %0b, actual %0b", oldest_write.last, pix_ch.last);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= '0;
        cfg_data             <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.kind          <= ckscb_pkg::KIND_LOAD;
        req_ch.texel_index   <= '0;
        req_ch.texel_value   <= '0;
        req_ch.column        <= '0;
        req_ch.x_origin      <= '0;
        req_ch.y_origin      <= '0;
        req_ch.sprite_width  <= '0;
        req_ch.sprite_height <= '0;
        req_ch.column_shift  <= '0;
        req_ch.outline       <= 1'b0;
        scr_width  = ckscb_pkg::RST_SCREEN_WIDTH;
        scr_height = ckscb_pkg::RST_SCREEN_HEIGHT;
        fb_pitch   = ckscb_pkg::RST_ROW_PITCH;
        pix_bytes  = ckscb_pkg::RST_PIXEL_BYTES;

        // Directed table, at reset settings: 320 x 200, pitch 320, one byte
        add_row(make_load(12'd0, 32'h1234_5678), 1'b0, 13'd0, 1'b0, 0, NO_WRITE);
        add_row(make_draw(0, 5, 7, 1, 1, 0, 1'b0), 1'b0, 13'd0, 1'b1, 1,
                '{24'd2245, 32'h78, 1'b1});
        add_row(make_draw(0, 5, 7, 1, 1, 0, 1'b1), 1'b0, 13'd0, 1'b1, 1,
                '{24'd2245, 32'h0, 1'b1});
        add_row(make_load(12'd4095, 32'hffff_ffff), 1'b0, 13'd0, 1'b0, 0, NO_WRITE);
        add_row(make_load(12'd1, 32'habcd_efff), 1'b0, 13'd0, 1'b0, 0, NO_WRITE);
        // Transparent top texel, opaque one below it marked last
        add_row(make_draw(0, 5, 7, 1, 2, 0, 1'b0), 1'b0, 13'd0, 1'b1, 1,
                '{24'd2565, 32'h78, 1'b1});
        // Zero width, zero height
        add_row(make_draw(0, 5, 7, 0, 1, 0, 1'b0), 1'b0, 13'd0, 1'b1, 0, NO_WRITE);
        add_row(make_draw(0, 5, 7, 1, 0, 0, 1'b0), 1'b0, 13'd0, 1'b1, 0, NO_WRITE);
        // Column past the sprite, right of, left of and below the screen
        add_row(make_draw(3, 5, 7, 3, 1, 0, 1'b0), 1'b0, 13'd0, 1'b1, 0, NO_WRITE);
        add_row(make_draw(0, 4095, 7, 1, 1, 0, 1'b0), 1'b0, 13'd0, 1'b1, 0, NO_WRITE);
        add_row(make_draw(0, -4096, 7, 1, 1, 0, 1'b0), 1'b0, 13'd0, 1'b1, 0, NO_WRITE);
        add_row(make_draw(0, 5, 4095, 1, 1, 0, 1'b0), 1'b0, 13'd0, 1'b1, 0, NO_WRITE);
        // Top clip, bottom clip, tall sprite with oversize shift, store wrap, outline
        add_row(make_draw(0, 5, -3, 1, 8, 3, 1'b0), 1'b0, 13'd0, 1'b0, 0, NO_WRITE);
        add_row(make_draw(0, 10, 195, 1, 10, 4, 1'b0), 1'b0, 13'd0, 1'b0, 0, NO_WRITE);
        add_row(make_draw(0, 0, 0, 2, 127, 7, 1'b0), 1'b0, 13'd0, 1'b0, 0, NO_WRITE);
        add_row(make_draw(0, 0, 20, 4096, 64, 5, 1'b0), 1'b0, 13'd0, 1'b0, 0, NO_WRITE);
        add_row(make_draw(7, -5, 0, 8, 4, 2, 1'b1), 1'b0, 13'd0, 1'b0, 0, NO_WRITE);
        // Two- and four-byte pixels draw; bad size codes draw nothing
        add_row(make_draw(0, 5, 7, 1, 1, 0, 1'b0), 1'b1, 13'd3, 1'b1, 0, NO_WRITE);
        add_row(make_draw(0, 5, 7, 1, 1, 0, 1'b0), 1'b1, 13'd0, 1'b1, 0, NO_WRITE);
        add_row(make_draw(0, 5, 7, 1, 1, 0, 1'b0), 1'b1, 13'd2, 1'b1, 1,
                '{24'd2245, 32'h5678, 1'b1});
        add_row(make_draw(0, 5, 7, 1, 1, 0, 1'b0), 1'b1, 13'd4, 1'b1, 1,
                '{24'd2245, 32'h1234_5678, 1'b1});
        add_row(make_draw(0, 5, 7, 1, 1, 0, 1'b0), 1'b1, 13'h1fff, 1'b1, 0, NO_WRITE);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].reconfig)
            begin
                settle();
                write_reg(ckscb_pkg::REG_PIXEL_BYTES, directed_rows[i].pb_data);
                cfg_we <= 1'b0;
            end
            issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].typed_n,
                  directed_rows[i].typed_wr);
        end

        // Random phases, each opening with back-to-back requests
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            settle();
            configure_phase(phase);
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                idle_off = (n < 6);
                if ($urandom_range(0, 99) < 30)
                    issue(random_load(), 1'b0, 0, NO_WRITE);
                else
                    issue(random_draw(), 1'b0, 0, NO_WRITE);
            end
            idle_off = 1'b0;
        end

        settle();
        if (expected_writes.size() != 0)
        begin
            $error("%0d expected writes never arrived", expected_writes.size());
            error_count++;
        end
        if (error_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
